[rtl/radix_text_to_integer_defines.svh]
// Assertion helpers for the file that carries checks.
`ifndef RADIX_TEXT_TO_INTEGER_DEFINES_SVH
`define RADIX_TEXT_TO_INTEGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rtti_pkg.sv]
package rtti_pkg;

    // Core widths of the parser.
    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;
    localparam int RADIX_WIDTH  = 6;
    localparam int CHAR_WIDTH   = 8;
    localparam int DIGIT_WIDTH  = 6;
    localparam int PROD_WIDTH   = VALUE_WIDTH + RADIX_WIDTH;

    // Widths of the result ports.
    localparam int OUT_VALUE_WIDTH  = 64;
    localparam int OUT_OFFSET_WIDTH = 16;

    // Queue between the classifier and the execution stage; depth of at least two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;
    localparam logic [ADDR_WIDTH-3:0] REG_RADIX = '0;
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 6'd36;

    // Class of one character as seen by the execution stage.
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_MINUS,
        CLS_PLUS,
        CLS_DIGIT,
        CLS_END
    } char_class_t;

    // Parse phase.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // One classified word in the queue, with the radix it was classified under.
    typedef struct packed {
        logic                   start;
        char_class_t            cls;
        logic [DIGIT_WIDTH-1:0] digit;
        logic [RADIX_WIDTH-1:0] base;
    } item_t;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/rtti_front.sv]
module rtti_front (
    input  logic [rtti_pkg::CHAR_WIDTH-1:0]  ch,
    input  logic                             start_req,
    input  logic [rtti_pkg::RADIX_WIDTH-1:0] radix,
    output rtti_pkg::item_t                  item
);

    // Digit value of a character, or DIGIT_NONE when it is not a digit.
    function automatic logic [rtti_pkg::DIGIT_WIDTH-1:0] digit_of(
        input logic [rtti_pkg::CHAR_WIDTH-1:0] c
    );
        logic [rtti_pkg::DIGIT_WIDTH-1:0] d;
        begin
            d = rtti_pkg::DIGIT_NONE;
            if (c >= rtti_pkg::CHAR_0 && c <= rtti_pkg::CHAR_9)
            begin
                d = rtti_pkg::DIGIT_WIDTH'(c - rtti_pkg::CHAR_0);
            end
            else if (c >= rtti_pkg::CHAR_UA && c <= rtti_pkg::CHAR_UZ)
            begin
                d = rtti_pkg::DIGIT_WIDTH'(c - rtti_pkg::CHAR_UA) + rtti_pkg::DIGIT_TEN;
            end
            else if (c >= rtti_pkg::CHAR_LA && c <= rtti_pkg::CHAR_LZ)
            begin
                d = rtti_pkg::DIGIT_WIDTH'(c - rtti_pkg::CHAR_LA) + rtti_pkg::DIGIT_TEN;
            end
            return d;
        end
    endfunction

    logic [rtti_pkg::RADIX_WIDTH-1:0] base;
    logic [rtti_pkg::DIGIT_WIDTH-1:0] digit;
    logic                             digit_ok;

    // Radix above the largest digit acts like the largest radix.
    assign base  = (radix > rtti_pkg::RADIX_MAX) ? rtti_pkg::RADIX_MAX : radix;
    assign digit = digit_of(ch);

    // A NUL decodes as no digit, so it can never pass this compare.
    assign digit_ok = (base >= rtti_pkg::RADIX_WIDTH'(2)) && (digit < base);

    // Classify the character; a digit outside the radix ends the parse.
    always_comb
    begin
        item.start = start_req;
        item.digit = digit;
        item.base  = base;
        priority if (ch == rtti_pkg::CHAR_SPACE)
        begin
            item.cls = rtti_pkg::CLS_SPACE;
        end
        else if (ch == rtti_pkg::CHAR_MINUS)
        begin
            item.cls = rtti_pkg::CLS_MINUS;
        end
        else if (ch == rtti_pkg::CHAR_PLUS)
        begin
            item.cls = rtti_pkg::CLS_PLUS;
        end
        else if (digit_ok)
        begin
            item.cls = rtti_pkg::CLS_DIGIT;
        end
        else
        begin
            item.cls = rtti_pkg::CLS_END;
        end
    end

endmodule

[rtl/rtti_queue.sv]
module rtti_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rtti_pkg::item_t      push_item,
    input  logic                 pop,
    output rtti_pkg::item_t      head_item,
    output rtti_pkg::q_status_t  status
);

    rtti_pkg::item_t                  entry_reg [rtti_pkg::QUEUE_DEPTH];
    logic [rtti_pkg::QPTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rtti_pkg::QPTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rtti_pkg::QCNT_WIDTH-1:0]  count_reg, count_next;

    localparam logic [rtti_pkg::QPTR_WIDTH-1:0] LAST_PTR =
        rtti_pkg::QPTR_WIDTH'(rtti_pkg::QUEUE_DEPTH - 1);
    localparam logic [rtti_pkg::QCNT_WIDTH-1:0] FULL_COUNT =
        rtti_pkg::QCNT_WIDTH'(rtti_pkg::QUEUE_DEPTH);

    // Status flags.
    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign head_item    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/rtti_back.sv]
module rtti_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rtti_pkg::item_t                        head_item,
    input  logic                                   head_valid,
    output logic                                   pop,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [rtti_pkg::OUT_VALUE_WIDTH-1:0] value,
    output logic [rtti_pkg::OUT_OFFSET_WIDTH-1:0]  end_offset,
    output logic                                   overflowed
);

    localparam int VW = rtti_pkg::VALUE_WIDTH;
    localparam int OW = rtti_pkg::OFFSET_WIDTH;
    localparam int PW = rtti_pkg::PROD_WIDTH;

    rtti_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic             negative_reg, negative_next, negative_eff;
    logic [VW-1:0]    acc_reg, acc_next, acc_eff;
    logic [OW-1:0]    consumed_reg, consumed_next, consumed_eff;
    logic             wrap_reg, wrap_next, wrap_eff;

    logic             result_valid_reg, result_valid_next;
    logic signed [rtti_pkg::OUT_VALUE_WIDTH-1:0] value_reg, value_next;
    logic [rtti_pkg::OUT_OFFSET_WIDTH-1:0] end_offset_reg, end_offset_next;
    logic             overflowed_reg, overflowed_next;

    logic             active, take_space, take_sign, take_digit, finish;
    logic [PW-1:0]    product_sum;
    logic [VW-1:0]    magnitude, signed_val;
    logic [OW-1:0]    offset_raw;
    logic [31:0]      offset_wide;

    // Take the head word whenever the output register is free or draining.
    assign pop = head_valid && (!result_valid_reg || !result_stall);

    // Result word outputs.
    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign end_offset   = end_offset_reg;
    assign overflowed   = overflowed_reg;

    // A start word clears the parse state before the character is used.
    always_comb
    begin
        if (head_item.start)
        begin
            phase_eff    = rtti_pkg::PH_SKIP;
            negative_eff = 1'b0;
            acc_eff      = '0;
            consumed_eff = '0;
            wrap_eff     = 1'b0;
        end
        else
        begin
            phase_eff    = phase_reg;
            negative_eff = negative_reg;
            acc_eff      = acc_reg;
            consumed_eff = consumed_reg;
            wrap_eff     = wrap_reg;
        end
    end

    // Decide what the popped word does.
    always_comb
    begin
        active     = pop && (phase_eff != rtti_pkg::PH_DONE);
        take_space = active && (phase_eff == rtti_pkg::PH_SKIP)
                     && (head_item.cls == rtti_pkg::CLS_SPACE);
        take_sign  = active && (phase_eff == rtti_pkg::PH_SKIP)
                     && (head_item.cls == rtti_pkg::CLS_MINUS
                         || head_item.cls == rtti_pkg::CLS_PLUS);
        take_digit = active && (head_item.cls == rtti_pkg::CLS_DIGIT);
        finish     = active && !take_space && !take_sign && !take_digit;
    end

    // One multiply-add per character; the bits above the value width flag a wrap.
    assign product_sum = PW'(acc_eff) * PW'(head_item.base) + PW'(head_item.digit);

    // Phase transitions.
    always_comb
    begin
        priority if (finish)
        begin
            phase_next = rtti_pkg::PH_DONE;
        end
        else if (take_sign)
        begin
            phase_next = rtti_pkg::PH_SIGN;
        end
        else if (take_digit)
        begin
            phase_next = rtti_pkg::PH_DIGITS;
        end
        else if (pop)
        begin
            phase_next = phase_eff;
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

    // Data state and result word.
    always_comb
    begin
        negative_next = pop ? negative_eff : negative_reg;
        acc_next      = pop ? acc_eff : acc_reg;
        consumed_next = pop ? consumed_eff : consumed_reg;
        wrap_next     = pop ? wrap_eff : wrap_reg;

        if (take_sign && head_item.cls == rtti_pkg::CLS_MINUS)
        begin
            negative_next = 1'b1;
        end
        if (take_digit)
        begin
            acc_next  = product_sum[VW-1:0];
            wrap_next = wrap_eff || (product_sum[PW-1:VW] != '0);
        end
        if ((take_space || take_sign || take_digit) && (consumed_eff != '1))
        begin
            consumed_next = consumed_eff + 1'b1;
        end

        // Without digits the value and the offset are both zero.
        magnitude   = (phase_eff == rtti_pkg::PH_DIGITS) ? acc_eff : '0;
        signed_val  = negative_eff ? (VW'(0) - magnitude) : magnitude;
        offset_raw  = (phase_eff == rtti_pkg::PH_DIGITS) ? consumed_eff : '0;
        offset_wide = 32'(offset_raw);

        value_next      = value_reg;
        end_offset_next = end_offset_reg;
        overflowed_next = overflowed_reg;
        if (finish)
        begin
            value_next      = rtti_pkg::OUT_VALUE_WIDTH'($signed(signed_val));
            end_offset_next = (offset_wide > 32'h0000_FFFF)
                              ? 16'hFFFF : offset_wide[15:0];
            overflowed_next = wrap_eff;
        end

        if (finish)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    // Parse state and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= rtti_pkg::PH_SKIP;
            negative_reg     <= 1'b0;
            acc_reg          <= '0;
            consumed_reg     <= '0;
            wrap_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            value_reg        <= '0;
            end_offset_reg   <= '0;
            overflowed_reg   <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            acc_reg          <= acc_next;
            consumed_reg     <= consumed_next;
            wrap_reg         <= wrap_next;
            result_valid_reg <= result_valid_next;
            value_reg        <= value_next;
            end_offset_reg   <= end_offset_next;
            overflowed_reg   <= overflowed_next;
        end
    end

endmodule

[rtl/radix_text_to_integer.sv]
`include "radix_text_to_integer_defines.svh"

// Streaming strtol-style integer parser. Characters arrive one word per cycle on the item
// channel; leading spaces are skipped, one sign may follow, and digits 0-9, A-Z and a-z
// accumulate in the radix held in the APB register at address 0 (reset 10, values above 36
// act as 36). The first NUL, non-digit or out-of-radix digit ends the string and yields one
// result word with the 64-bit value, the saturating count of consumed characters and a wrap
// flag; start_req begins a new string. The block sustains one character per cycle: a front
// classifier feeds a two-word queue, and the back stage does one 64x6 multiply-add per
// character, which sets the rate. The terminating character passes through the queue, and
// the back stage then registers its result word, unless an earlier result is still held in
// the output register; while a result is held the queue fills and the input stalls. There
// is no clearing pass after reset.
module radix_text_to_integer (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rtti_pkg::ADDR_WIDTH-1:0]         paddr,
    input  logic [rtti_pkg::DATA_WIDTH-1:0]         pwdata,
    output logic [rtti_pkg::DATA_WIDTH-1:0]         prdata,
    output logic                                    pready,
    // Character channel.
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [rtti_pkg::CHAR_WIDTH-1:0]         ch,
    input  logic                                    start_req,
    // Result channel.
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [rtti_pkg::OUT_VALUE_WIDTH-1:0] value,
    output logic [rtti_pkg::OUT_OFFSET_WIDTH-1:0]   end_offset,
    output logic                                    overflowed
);

    logic [rtti_pkg::RADIX_WIDTH-1:0] radix_reg, radix_next;
    logic                             reg_hit;
    rtti_pkg::item_t                  front_item, head_item;
    rtti_pkg::q_status_t              q_status;
    logic                             push, pop;

    // Register decode.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[rtti_pkg::ADDR_WIDTH-1:2] == rtti_pkg::REG_RADIX);

    always_comb
    begin
        radix_next = radix_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            radix_next = pwdata[rtti_pkg::RADIX_WIDTH-1:0];
        end
        prdata = reg_hit ? rtti_pkg::DATA_WIDTH'(radix_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rtti_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Input handshake goes straight into the queue.
    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    rtti_front u_front (
        .ch        (ch),
        .start_req (start_req),
        .radix     (radix_reg),
        .item      (front_item)
    );

    rtti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    rtti_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .head_valid   (!q_status.empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .end_offset   (end_offset),
        .overflowed   (overflowed)
    );

    // A word taken in is visible in the queue on the next cycle.
    `RTTI_ASSERT_NEXT(a_push_lands, clk, rst_n, item_valid && !item_stall, !q_status.empty, "accepted word missing from queue")
    // A held result blocks the execution stage.
    `RTTI_ASSERT_SAME(a_no_pop_on_hold, clk, rst_n, result_valid && result_stall, !pop, "word consumed while result held")
    // A wrap can only follow at least one consumed digit.
    `RTTI_ASSERT_SAME(a_wrap_has_digits, clk, rst_n, result_valid && overflowed, end_offset != '0, "wrap flagged without digits")

endmodule
